// ----- rtl/jsym_pkg.sv -----
// Shared types and constants for the Jacobi symbol unit.
// Depends on nothing; every other file imports it.
`default_nettype none

package jsym_pkg;

	localparam int JSYM_DATA_WIDTH = 64;

	typedef struct packed {
		logic signed [63:0] value_a;
		logic [62:0]        modulus_n;
	} jsym_req_t;

	typedef struct packed {
		logic signed [1:0] symbol;
		logic              bad_modulus;
	} jsym_rsp_t;

	// Datapath commands issued by the controller.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DIV_STEP,
		CMD_DIV_END,
		CMD_HALVE,
		CMD_SWAP,
		CMD_FINISH
	} jsym_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DIV_END,
		ST_CHECK,
		ST_DONE
	} jsym_state_t;

	typedef struct packed {
		logic a_zero;
		logic a_odd;
		logic div_last;
		logic bad;
	} jsym_status_t;

	localparam logic signed [1:0] SYM_ZERO = 2'sb00;
	localparam logic signed [1:0] SYM_POS  = 2'sb01;
	localparam logic signed [1:0] SYM_NEG  = 2'sb11;

endpackage

`default_nettype wire

// ----- rtl/jsym_dp.sv -----
// Datapath of the Jacobi symbol unit: operand registers, a restoring
// divider that produces one remainder bit per cycle, and the result register.
// Depends on jsym_pkg.
`default_nettype none

module jsym_dp #(
	parameter int DATA_WIDTH = jsym_pkg::JSYM_DATA_WIDTH
) (
	input  wire                          clk,
	input  wire jsym_pkg::jsym_cmd_t     cmd,
	input  wire jsym_pkg::jsym_req_t     req_data,
	output jsym_pkg::jsym_status_t       status,
	output jsym_pkg::jsym_rsp_t          rsp_data
);
	import jsym_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

	logic [W-1:0]     a_q;
	logic [W-2:0]     n_q;
	logic [W-2:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             sign_q;
	logic             bad_q;
	jsym_rsp_t        res_q;

	logic [W-1:0] a_in;
	logic [W-2:0] n_in;
	logic [W-1:0] trial;
	logic [W-1:0] diff;
	logic         fits;
	logic [W-2:0] rem_low;
	logic [W-2:0] rem_neg;
	logic         halve_flip;
	logic         swap_flip;

	assign a_in = req_data.value_a[W-1:0];
	assign n_in = req_data.modulus_n[W-2:0];

	// One restoring division step: shift in the next dividend bit and subtract if it fits.
	assign trial   = {rem_q, a_q[W-1]};
	assign diff    = trial - {1'b0, n_q};
	assign fits    = trial >= {1'b0, n_q};
	assign rem_low = rem_q;
	assign rem_neg = n_q - rem_low;

	assign halve_flip = (n_q[2:0] == 3'd3) || (n_q[2:0] == 3'd5);
	assign swap_flip  = (a_q[1:0] == 2'd3) && (n_q[1:0] == 2'd3);

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				neg_q  <= a_in[W-1];
				a_q    <= a_in[W-1] ? (~a_in + W'(1)) : a_in;
				n_q    <= n_in;
				bad_q  <= ~n_in[0];
				sign_q <= 1'b0;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			CMD_DIV_STEP: begin
				// The remainder stays below the modulus, so its top bit is always clear.
				rem_q <= fits ? diff[W-2:0] : trial[W-2:0];
				a_q   <= {a_q[W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			CMD_DIV_END: begin
				// A negative operand maps its remainder r to n - r, except when r is zero.
				if (neg_q && (rem_low != '0)) begin
					a_q <= {1'b0, rem_neg};
				end else begin
					a_q <= {1'b0, rem_low};
				end
				neg_q <= 1'b0;
			end
			CMD_HALVE: begin
				a_q    <= {1'b0, a_q[W-1:1]};
				sign_q <= sign_q ^ halve_flip;
			end
			CMD_SWAP: begin
				a_q    <= {1'b0, n_q};
				n_q    <= a_q[W-2:0];
				sign_q <= sign_q ^ swap_flip;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			CMD_FINISH: begin
				res_q.bad_modulus <= bad_q;
				if (bad_q || (n_q != (W-1)'(1))) begin
					res_q.symbol <= SYM_ZERO;
				end else begin
					res_q.symbol <= sign_q ? SYM_NEG : SYM_POS;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.a_zero   = (a_q == '0);
	assign status.a_odd    = a_q[0];
	assign status.div_last = (cnt_q == CNT_LAST);
	assign status.bad      = bad_q;

	assign rsp_data = res_q;

endmodule

`default_nettype wire

// ----- rtl/jsym_ctrl.sv -----
// Controller of the Jacobi symbol unit: sequences load, division, halving
// and swap rounds, and owns the request and response handshakes.
// Depends on jsym_pkg.
`default_nettype none

module jsym_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	input  wire jsym_pkg::jsym_status_t  status,
	output jsym_pkg::jsym_cmd_t          cmd
);
	import jsym_pkg::*;

	jsym_state_t state_q;
	jsym_state_t state_nxt;
	logic        rsp_valid_q;
	logic        out_free;

	assign out_free = ~rsp_valid_q | rsp_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				priority if (status.bad) begin
					state_nxt = ST_DONE;
				end else if (status.div_last) begin
					state_nxt = ST_DIV_END;
				end else begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIV_END: state_nxt = ST_CHECK;
			ST_CHECK: begin
				priority if (status.a_zero) begin
					state_nxt = ST_DONE;
				end else if (status.a_odd) begin
					state_nxt = ST_DIVIDE;
				end else begin
					state_nxt = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = CMD_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd = CMD_LOAD;
				end
			end
			ST_DIVIDE: begin
				if (!status.bad) begin
					cmd = CMD_DIV_STEP;
				end
			end
			ST_DIV_END: cmd = CMD_DIV_END;
			ST_CHECK: begin
				priority if (status.a_zero) begin
					cmd = CMD_NONE;
				end else if (status.a_odd) begin
					cmd = CMD_SWAP;
				end else begin
					cmd = CMD_HALVE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd = CMD_FINISH;
				end
			end
			default: cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ----- rtl/jacobi_symbol.sv -----
// Jacobi symbol unit. One request at a time; the bit-serial divider performs one modulo
// reduction at the start and one after each swap, and factors of two are stripped between
// reductions. An even or zero modulus skips the division and answers directly. A new request
// is taken the cycle after the result moves to the output register, so a request is never
// taken while the previous one is still in flight. Reset is asynchronous, active low, and
// clears only control.
`default_nettype none

module jacobi_symbol #(
	parameter int DATA_WIDTH = jsym_pkg::JSYM_DATA_WIDTH
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       req_valid,
	output logic                      req_ready,
	input  wire jsym_pkg::jsym_req_t  req_data,
	output logic                      rsp_valid,
	input  wire                       rsp_ready,
	output jsym_pkg::jsym_rsp_t       rsp_data
);
	import jsym_pkg::*;

	jsym_cmd_t    cmd;
	jsym_status_t status;

	jsym_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	jsym_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.req_data (req_data),
		.status   (status),
		.rsp_data (rsp_data)
	);

	// Only one request is in flight, so an accepted request closes the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while busy");

	// A bad modulus always reports a zero symbol.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.bad_modulus) |-> (rsp_data.symbol == SYM_ZERO))
		else $error("bad modulus with nonzero symbol");

	// The symbol code for -2 never appears.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.symbol != 2'sb10))
		else $error("invalid symbol code");

endmodule

`default_nettype wire
